// File: rtl/core/ctl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctl_pkg
// Shared types and codes for the cache tag lookup and replacement block.
// ----------------------------------------------------------------------------
package ctl_pkg;

    localparam int TagW   = 32;
    localparam int StampW = 32;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_RULE  = 2'd1;
    localparam logic [1:0] CFG_OBITS = 2'd2;
    localparam logic [1:0] CFG_BBITS = 2'd3;

    localparam logic [1:0] MODE_DIRECT = 2'd0;
    localparam logic [1:0] MODE_SET    = 2'd1;
    localparam logic [1:0] MODE_FULL   = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    localparam logic RULE_FIFO = 1'b0;
    localparam logic RULE_LRU  = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [TagW-1:0]   tag;
        logic [StampW-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic free;
        logic match;
        logic older;
    } way_flags_t;

endpackage

// File: rtl/core/cache_tag_lookup_replace.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cache_tag_lookup_replace
// Cache tag lookup with FIFO or LRU replacement over a single entry store.
// ----------------------------------------------------------------------------
// After reset the block sweeps its entry store, one entry per cycle,
// before it accepts the first item; configuration writes are taken during
// the sweep. Each item is then handled by one compare unit that visits the
// ways of the selected set one per cycle through the single read port of
// the entry store. A hit or a fill into a free way ends the visit early.
// The ways visited number 1 direct mapped, up to 4 in four-way mode and up
// to 2^b fully associative, with b the block count bits. A FIFO miss shifts
// the set down one entry per cycle. Results wait in an output register, so
// the next item can start while one is pending.
// ----------------------------------------------------------------------------
module cache_tag_lookup_replace
    import ctl_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] word_address

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] evicted_tag
    output logic [1:0]  m_axis_tuser    // [0] hit, [1] evicted_valid
);

    localparam int IW      = $clog2(MAX_BLOCKS);
    localparam int MaxL    = $clog2(MAX_BLOCKS + 1) - 1;
    localparam int LastIdx = MAX_BLOCKS - 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        mode_reg;
    logic              rule_reg;
    logic [3:0]        obits_reg;
    logic [3:0]        bbits_reg;
    logic [IW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [IW-1:0]     chk_ptr_reg, chk_ptr_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [StampW-1:0] count_reg, count_next;
    logic              m_valid_reg, m_valid_next;

    logic [TagW-1:0]   tag_reg, tag_next;
    logic [IW-1:0]     base_reg, base_next;
    logic [IW-1:0]     last_reg, last_next;
    logic [StampW-1:0] min_reg, min_next;
    logic [IW-1:0]     victim_reg, victim_next;
    logic [TagW-1:0]   victim_tag_reg, victim_tag_next;
    logic [TagW-1:0]   first_tag_reg, first_tag_next;
    logic              res_hit_reg, res_hit_next;
    logic              res_ev_reg, res_ev_next;
    logic [TagW-1:0]   res_tag_reg, res_tag_next;
    logic              m_hit_reg, m_hit_next;
    logic              m_ev_reg, m_ev_next;
    logic [TagW-1:0]   m_tag_reg, m_tag_next;

    logic [31:0]       byte_addr;
    logic [31:0]       line;
    logic [4:0]        bl;
    logic [IW-1:0]     blk_mask;
    logic [IW-1:0]     set_mask;
    logic [IW-1:0]     acc_base;
    logic [IW-1:0]     acc_last;
    logic [TagW-1:0]   acc_tag;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    entry_t            ram_wdata;
    entry_t            ram_rdata;
    way_flags_t        flags;
    logic [IW-1:0]     vic_idx;
    logic [TagW-1:0]   vic_tag;
    entry_t            new_entry;

    ctl_entry_ram #(
        .DEPTH (MAX_BLOCKS),
        .AW    (IW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    ctl_way_unit u_way (
        .entry     (ram_rdata),
        .key       (tag_reg),
        .min_stamp (min_reg),
        .first     (chk_ptr_reg == base_reg),
        .flags     (flags)
    );

    always_comb
    begin
        byte_addr = {s_axis_tdata[29:0], 2'b00};
        line      = byte_addr >> obits_reg;
        if ({1'b0, bbits_reg} > 5'(MaxL))
        begin
            bl = 5'(MaxL);
        end
        else if (bbits_reg < 4'd2)
        begin
            bl = 5'd2;
        end
        else
        begin
            bl = {1'b0, bbits_reg};
        end
        blk_mask = ~({IW{1'b1}} << bl);
        set_mask = ~({IW{1'b1}} << (bl - 5'd2));
        unique case (mode_reg) inside
            MODE_DIRECT:
            begin
                acc_base = line[IW-1:0] & blk_mask;
                acc_last = acc_base;
                acc_tag  = byte_addr >> (bl + {1'b0, obits_reg});
            end
            MODE_SET:
            begin
                acc_base = IW'({line[IW-1:0] & set_mask, 2'b00});
                acc_last = acc_base + IW'(3);
                acc_tag  = byte_addr >> ((bl - 5'd2) + {1'b0, obits_reg});
            end
            MODE_FULL, MODE_SPARE:
            begin
                acc_base = '0;
                acc_last = blk_mask;
                acc_tag  = line;
            end
            default:
            begin
                acc_base = '0;
                acc_last = blk_mask;
                acc_tag  = line;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        rd_ptr_next     = rd_ptr_reg;
        chk_ptr_next    = chk_ptr_reg;
        chk_vld_next    = chk_vld_reg;
        count_next      = count_reg;
        m_valid_next    = m_valid_reg;
        tag_next        = tag_reg;
        base_next       = base_reg;
        last_next       = last_reg;
        min_next        = min_reg;
        victim_next     = victim_reg;
        victim_tag_next = victim_tag_reg;
        first_tag_next  = first_tag_reg;
        res_hit_next    = res_hit_reg;
        res_ev_next     = res_ev_reg;
        res_tag_next    = res_tag_reg;
        m_hit_next      = m_hit_reg;
        m_ev_next       = m_ev_reg;
        m_tag_next      = m_tag_reg;
        ram_we          = 1'b0;
        ram_waddr       = chk_ptr_reg;
        ram_wdata       = '0;
        new_entry.valid = 1'b1;
        new_entry.tag   = tag_reg;
        new_entry.stamp = count_reg;
        vic_idx         = flags.older ? chk_ptr_reg : victim_reg;
        vic_tag         = flags.older ? ram_rdata.tag : victim_tag_reg;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we      = 1'b1;
                ram_waddr   = rd_ptr_reg;
                rd_ptr_next = rd_ptr_reg + IW'(1);
                if (rd_ptr_reg == IW'(LastIdx))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    tag_next     = acc_tag;
                    base_next    = acc_base;
                    last_next    = acc_last;
                    rd_ptr_next  = acc_base;
                    chk_vld_next = 1'b0;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_ptr_next  = rd_ptr_reg + IW'(1);
                chk_ptr_next = rd_ptr_reg;
                chk_vld_next = 1'b1;
                if (chk_vld_reg)
                begin
                    if (flags.free || flags.match)
                    begin
                        ram_we       = 1'b1;
                        ram_wdata    = new_entry;
                        res_hit_next = flags.match;
                        res_ev_next  = 1'b0;
                        res_tag_next = '0;
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        if (flags.older)
                        begin
                            min_next        = ram_rdata.stamp;
                            victim_next     = chk_ptr_reg;
                            victim_tag_next = ram_rdata.tag;
                        end
                        if (chk_ptr_reg == base_reg)
                        begin
                            first_tag_next = ram_rdata.tag;
                        end
                        if (chk_ptr_reg == last_reg)
                        begin
                            res_hit_next = 1'b0;
                            res_ev_next  = 1'b1;
                            if (rule_reg == RULE_LRU)
                            begin
                                ram_we       = 1'b1;
                                ram_waddr    = vic_idx;
                                ram_wdata    = new_entry;
                                res_tag_next = vic_tag;
                                state_next   = S_EMIT;
                            end
                            else
                            begin
                                res_tag_next = (chk_ptr_reg == base_reg) ?
                                               ram_rdata.tag : first_tag_reg;
                                if (base_reg == last_reg)
                                begin
                                    ram_we     = 1'b1;
                                    ram_wdata  = new_entry;
                                    state_next = S_EMIT;
                                end
                                else
                                begin
                                    rd_ptr_next  = base_reg + IW'(1);
                                    chk_vld_next = 1'b0;
                                    state_next   = S_SHIFT;
                                end
                            end
                        end
                    end
                end
            end
            S_SHIFT:
            begin
                rd_ptr_next  = rd_ptr_reg + IW'(1);
                chk_ptr_next = rd_ptr_reg;
                chk_vld_next = 1'b1;
                if (chk_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = chk_ptr_reg - IW'(1);
                    ram_wdata = ram_rdata;
                    if (chk_ptr_reg == last_reg)
                    begin
                        state_next = S_FILL;
                    end
                end
            end
            S_FILL:
            begin
                ram_we     = 1'b1;
                ram_waddr  = last_reg;
                ram_wdata  = new_entry;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_hit_next   = res_hit_reg;
                    m_ev_next    = res_ev_reg;
                    m_tag_next   = res_tag_reg;
                    count_next   = count_reg + StampW'(1);
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            rd_ptr_reg  <= '0;
            chk_ptr_reg <= '0;
            chk_vld_reg <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            mode_reg    <= MODE_DIRECT;
            rule_reg    <= RULE_FIFO;
            obits_reg   <= 4'd4;
            bbits_reg   <= 4'd10;
        end
        else
        begin
            state_reg   <= state_next;
            rd_ptr_reg  <= rd_ptr_next;
            chk_ptr_reg <= chk_ptr_next;
            chk_vld_reg <= chk_vld_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MODE:  mode_reg  <= cfg_data[1:0];
                    CFG_RULE:  rule_reg  <= cfg_data[0];
                    CFG_OBITS: obits_reg <= cfg_data;
                    CFG_BBITS: bbits_reg <= cfg_data;
                    default:   mode_reg  <= mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg        <= tag_next;
        base_reg       <= base_next;
        last_reg       <= last_next;
        min_reg        <= min_next;
        victim_reg     <= victim_next;
        victim_tag_reg <= victim_tag_next;
        first_tag_reg  <= first_tag_next;
        res_hit_reg    <= res_hit_next;
        res_ev_reg     <= res_ev_next;
        res_tag_reg    <= res_tag_next;
        m_hit_reg      <= m_hit_next;
        m_ev_reg       <= m_ev_next;
        m_tag_reg      <= m_tag_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_tag_reg;
    assign m_axis_tuser  = {m_ev_reg, m_hit_reg};

endmodule

// File: rtl/core/ctl_way_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctl_way_unit
// Compare unit shared by every way visit: free, tag match and age checks.
// ----------------------------------------------------------------------------
module ctl_way_unit
    import ctl_pkg::*;
(
    input  entry_t            entry,
    input  logic [TagW-1:0]   key,
    input  logic [StampW-1:0] min_stamp,
    input  logic              first,
    output way_flags_t        flags
);

    always_comb
    begin
        flags.free  = !entry.valid;
        flags.match = entry.valid && (entry.tag == key);
        flags.older = first || (entry.stamp < min_stamp);
    end

endmodule

// File: rtl/core/ctl_entry_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctl_entry_ram
// Entry store holding valid bit, tag and stamp, one write and one read port.
// ----------------------------------------------------------------------------
module ctl_entry_ram
    import ctl_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
